// ----- rtl/core/object_file_section_loader_defines.svh -----
// Assertion shorthands used by the checker file ofsl_checker.sv.
`ifndef OBJECT_FILE_SECTION_LOADER_DEFINES_SVH
`define OBJECT_FILE_SECTION_LOADER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define OFSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define OFSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define OFSL_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ofsl_pkg.sv -----
`timescale 1ns / 1ps
package ofsl_pkg;

    // Parser phase
    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_ADDR    = 4'd1,
        PH_COUNT   = 4'd2,
        PH_PAYLOAD = 4'd3,
        PH_SKIP    = 4'd4,
        PH_DRAIN   = 4'd5
    } t_phase;

    // Section being parsed
    typedef enum logic [2:0] {
        SK_CODE   = 3'd0,
        SK_SYMBOL = 3'd1,
        SK_FNAME  = 3'd2,
        SK_LINE   = 3'd3
    } t_sect;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_TRUNC = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    // Section header words
    localparam logic [15:0] HDR_CODE   = 16'hCADE;
    localparam logic [15:0] HDR_DATA   = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;
    localparam logic [15:0] HDR_FNAME  = 16'hF17E;
    localparam logic [15:0] HDR_LINE   = 16'h715E;

    // Line sections carry a fixed byte count
    localparam logic [15:0] LINE_LEN = 16'd6;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [15:0] word;
    } t_result;

endpackage

// ----- rtl/core/ofsl_in_reg.sv -----
`timescale 1ns / 1ps
module ofsl_in_reg
    import ofsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    // Valid bit, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- rtl/core/ofsl_parser.sv -----
`timescale 1ns / 1ps
module ofsl_parser
    import ofsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_res_valid,
    output t_result  o_res
);

    t_phase      r_phase,     n_phase;
    t_sect       r_sect,      n_sect;
    logic [7:0]  r_high_byte, n_high_byte;
    logic        r_have_high, n_have_high;
    logic [15:0] r_load_addr, n_load_addr;
    logic [15:0] r_remaining, n_remaining;

    logic        w_word_phase;
    logic        w_word_ready;
    logic [15:0] w_word;
    logic        w_res_valid;

    assign w_word       = {r_high_byte, i_beat.data_byte};
    assign w_word_phase = r_phase inside {PH_HEADER, PH_ADDR, PH_COUNT, PH_PAYLOAD};
    assign w_word_ready = w_word_phase && r_have_high;

    // Parser state, advanced on each valid beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_sect      <= SK_CODE;
            r_high_byte <= 8'd0;
            r_have_high <= 1'b0;
            r_load_addr <= 16'd0;
            r_remaining <= 16'd0;
        end else if (i_en && i_valid) begin
            r_phase     <= n_phase;
            r_sect      <= n_sect;
            r_high_byte <= n_high_byte;
            r_have_high <= n_have_high;
            r_load_addr <= n_load_addr;
            r_remaining <= n_remaining;
        end
    end

    // Next state and result
    always_comb begin
        n_phase     = r_phase;
        n_sect      = r_sect;
        n_high_byte = r_high_byte;
        n_have_high = r_have_high;
        n_load_addr = r_load_addr;
        n_remaining = r_remaining;
        w_res_valid = 1'b0;
        o_res       = '{kind: KIND_WRITE, addr: 16'd0, word: 16'd0};

        if (i_beat.end_of_stream) begin
            // End of stream: report status (none while draining) and restart
            n_phase     = PH_HEADER;
            n_sect      = SK_CODE;
            n_high_byte = 8'd0;
            n_have_high = 1'b0;
            n_load_addr = 16'd0;
            n_remaining = 16'd0;
            if (r_phase != PH_DRAIN) begin
                w_res_valid = 1'b1;
                o_res.kind  = (r_phase == PH_HEADER) ? KIND_DONE : KIND_TRUNC;
            end
        end else begin
            // Big-endian word assembly
            if (w_word_phase) begin
                if (!r_have_high) begin
                    n_high_byte = i_beat.data_byte;
                    n_have_high = 1'b1;
                end else begin
                    n_have_high = 1'b0;
                end
            end

            case (r_phase)
                PH_HEADER: begin
                    if (w_word_ready) begin
                        if (w_word == HDR_CODE || w_word == HDR_DATA) begin
                            n_sect  = SK_CODE;
                            n_phase = PH_ADDR;
                        end else if (w_word == HDR_SYMBOL) begin
                            n_sect  = SK_SYMBOL;
                            n_phase = PH_ADDR;
                        end else if (w_word == HDR_FNAME) begin
                            n_sect  = SK_FNAME;
                            n_phase = PH_COUNT;
                        end else if (w_word == HDR_LINE) begin
                            n_sect      = SK_LINE;
                            n_remaining = LINE_LEN;
                            n_phase     = PH_SKIP;
                        end else begin
                            n_phase     = PH_DRAIN;
                            w_res_valid = 1'b1;
                            o_res.kind  = KIND_BAD;
                            o_res.word  = w_word;
                        end
                    end
                end
                PH_ADDR: begin
                    if (w_word_ready) begin
                        if (r_sect == SK_CODE) begin
                            n_load_addr = w_word;
                        end
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (w_word_ready) begin
                        n_remaining = w_word;
                        if (w_word == 16'd0) begin
                            n_phase = PH_HEADER;
                        end else if (r_sect == SK_CODE) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (w_word_ready) begin
                        n_load_addr = r_load_addr + 16'd1;
                        n_remaining = r_remaining - 16'd1;
                        if (r_remaining == 16'd1) begin
                            n_phase = PH_HEADER;
                        end
                        w_res_valid = 1'b1;
                        o_res.kind  = KIND_WRITE;
                        o_res.addr  = r_load_addr;
                        o_res.word  = w_word;
                    end
                end
                PH_SKIP: begin
                    // Skipped sections count bytes, not words
                    n_remaining = r_remaining - 16'd1;
                    if (r_remaining == 16'd1) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_DRAIN;
                end
            endcase
        end
    end

    assign o_res_valid = w_res_valid && i_valid;

endmodule

// ----- rtl/core/ofsl_out_reg.sv -----
`timescale 1ns / 1ps
module ofsl_out_reg
    import ofsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Result valid, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/core/object_file_section_loader.sv -----
`timescale 1ns / 1ps
// Two-stage pipe: input register, then combinational parser, then output register.
// Throughput: one byte per cycle unless stalled; the parser state register is updated once per beat.
// A stalled result holds the whole pipe, so input stall follows output stall while a result waits.
// Reset is synchronous, active low: parser returns to expecting a section header, pipe empties.
module object_file_section_loader
    import ofsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_mem_address,
    output logic [15:0] o_mem_word
);

    logic     w_en;
    t_in_beat w_in_beat;
    logic     w_beat_valid;
    t_in_beat w_beat;
    logic     w_res_valid;
    t_result  w_res;
    t_result  w_out_res;

    // Pipe advances unless a result is waiting on a stalled sink
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_in_beat = '{data_byte: i_data_byte, end_of_stream: i_end_of_stream};

    ofsl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_beat  (w_in_beat),
        .o_valid (w_beat_valid),
        .o_beat  (w_beat)
    );

    ofsl_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_beat_valid),
        .i_beat      (w_beat),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ofsl_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_res_valid),
        .i_res   (w_res),
        .o_valid (o_valid),
        .o_res   (w_out_res)
    );

    assign o_result_kind = w_out_res.kind;
    assign o_mem_address = w_out_res.addr;
    assign o_mem_word    = w_out_res.word;

endmodule

// ----- rtl/core/ofsl_checker.sv -----
`timescale 1ns / 1ps
`include "object_file_section_loader_defines.svh"
module ofsl_checker
    import ofsl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_stream,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_result_kind,
    input logic [15:0] o_mem_address,
    input logic [15:0] o_mem_word
);

    // A stalled input beat is held by the sender
    `OFSL_ASSERT_NEXT(a_in_hold, i_valid && o_stall,
        i_valid && $stable(i_data_byte) && $stable(i_end_of_stream),
        "stalled input beat changed")

    // A stalled result beat holds
    `OFSL_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_result_kind) && $stable(o_mem_address) && $stable(o_mem_word),
        "stalled result changed")

    // Only memory writes carry an address
    `OFSL_ASSERT_NOW(a_addr_zero, o_valid && o_result_kind != KIND_WRITE,
        o_mem_address == 16'd0, "address on a status beat")

    // Load done and truncation carry no word
    `OFSL_ASSERT_NOW(a_word_zero,
        o_valid && (o_result_kind == KIND_DONE || o_result_kind == KIND_TRUNC),
        o_mem_word == 16'd0, "word on a done or truncated beat")

    // Reset empties the result register
    `OFSL_ASSERT_NEXT_RST(a_rst_empty, !i_rst_n, !o_valid, "result valid right after reset")

endmodule

bind object_file_section_loader ofsl_checker u_ofsl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_data_byte     (i_data_byte),
    .i_end_of_stream (i_end_of_stream),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_result_kind   (o_result_kind),
    .o_mem_address   (o_mem_address),
    .o_mem_word      (o_mem_word)
);

// ----- tb/ofsl_load_checker.sv -----
`timescale 1ns / 1ps
// Watches both channels, tracks the parser state per accepted beat and
// compares every result beat with the oldest predicted one.
module ofsl_load_checker
    import ofsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_result_kind,
    input  logic [15:0] i_mem_address,
    input  logic [15:0] i_mem_word,
    output int          o_fail_count,
    output int          o_pending
);

    // Parser copy
    t_phase      ph;
    t_sect       sect;
    logic [7:0]  hi_byte;
    logic        hi_pending;
    logic [15:0] next_addr;
    logic [15:0] left;

    t_result     load_events[$];
    t_result     want;
    int          failures = 0;

    task automatic clear_parser();
        ph         = PH_HEADER;
        sect       = SK_CODE;
        hi_byte    = '0;
        hi_pending = 1'b0;
        next_addr  = '0;
        left       = '0;
    endtask

    task automatic queue_event(input t_kind k, input logic [15:0] a, input logic [15:0] w);
        t_result r;
        r.kind = k;
        r.addr = a;
        r.word = w;
        load_events.push_back(r);
    endtask

    // Big-endian pairing: full goes high on the second byte of a word
    task automatic pair_byte(input logic [7:0] b, output logic full, output logic [15:0] w);
        w = '0;
        if (!hi_pending) begin
            hi_byte    = b;
            hi_pending = 1'b1;
            full       = 1'b0;
        end else begin
            hi_pending = 1'b0;
            w          = {hi_byte, b};
            full       = 1'b1;
        end
    endtask

    task automatic parse_beat(input logic [7:0] b, input logic eos);
        logic        full;
        logic [15:0] w;
        t_phase      was;
        if (eos) begin
            was = ph;
            clear_parser();
            // drained streams end silently
            if (was == PH_HEADER)
                queue_event(KIND_DONE, '0, '0);
            else if (was != PH_DRAIN)
                queue_event(KIND_TRUNC, '0, '0);
            return;
        end
        case (ph)
            PH_HEADER: begin
                pair_byte(b, full, w);
                if (full) begin
                    case (w)
                        HDR_CODE, HDR_DATA: begin
                            sect = SK_CODE;
                            ph   = PH_ADDR;
                        end
                        HDR_SYMBOL: begin
                            sect = SK_SYMBOL;
                            ph   = PH_ADDR;
                        end
                        HDR_FNAME: begin
                            sect = SK_FNAME;
                            ph   = PH_COUNT;
                        end
                        HDR_LINE: begin
                            sect = SK_LINE;
                            left = LINE_LEN;
                            ph   = PH_SKIP;
                        end
                        default: begin
                            ph = PH_DRAIN;
                            queue_event(KIND_BAD, '0, w);
                        end
                    endcase
                end
            end
            PH_ADDR: begin
                pair_byte(b, full, w);
                if (full) begin
                    // symbol sections carry an address that is not used
                    if (sect == SK_CODE)
                        next_addr = w;
                    ph = PH_COUNT;
                end
            end
            PH_COUNT: begin
                pair_byte(b, full, w);
                if (full) begin
                    left = w;
                    if (w == '0)
                        ph = PH_HEADER;
                    else
                        ph = (sect == SK_CODE) ? PH_PAYLOAD : PH_SKIP;
                end
            end
            PH_PAYLOAD: begin
                pair_byte(b, full, w);
                if (full) begin
                    queue_event(KIND_WRITE, next_addr, w);
                    next_addr = next_addr + 16'd1;
                    left      = left - 16'd1;
                    if (left == '0)
                        ph = PH_HEADER;
                end
            end
            PH_SKIP: begin
                left = left - 16'd1;
                if (left == '0)
                    ph = PH_HEADER;
            end
            default: ph = PH_DRAIN;
        endcase
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Results are checked before the input beat of the same edge is parsed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            load_events.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (load_events.size() == 0) begin
                    note_failure($sformatf("unexpected result beat: kind %0d addr %h word %h",
                        i_result_kind, i_mem_address, i_mem_word));
                end else begin
                    want = load_events.pop_front();
                    if (i_result_kind !== want.kind || i_mem_address !== want.addr ||
                        i_mem_word !== want.word)
                        note_failure($sformatf(
                            "mismatch: want kind %0d addr %h word %h, got kind %0d addr %h word %h",
                            want.kind, want.addr, want.word,
                            i_result_kind, i_mem_address, i_mem_word));
                end
            end
            if (i_in_valid && !i_in_stall)
                parse_beat(i_data_byte, i_end_of_stream);
        end
        o_pending    <= load_events.size();
        o_fail_count <= failures;
    end

endmodule

// ----- tb/object_file_section_loader_tb.sv -----
`timescale 1ns / 1ps
module object_file_section_loader_tb;
    import ofsl_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 517;
    localparam int SEND_IDLE[3] = '{18, 57, 0};
    localparam int RECV_IDLE[3] = '{57, 18, 0};
    localparam logic [15:0] HEADERS[5] = '{HDR_CODE, HDR_DATA, HDR_SYMBOL, HDR_FNAME, HDR_LINE};

    // Directed beats: {end_of_stream, data_byte}
    localparam logic [8:0] DIRECTED[39] = '{
        // code section at FFFF, two words, address wraps
        9'h0CA, 9'h0DE, 9'h0FF, 9'h0FF, 9'h000, 9'h002, 9'h012, 9'h034, 9'h0AB, 9'h0CD,
        // file name, one byte
        9'h0F1, 9'h07E, 9'h000, 9'h001, 9'h041,
        // line section
        9'h071, 9'h05E, 9'h001, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006,
        // symbol section, zero count
        9'h0C3, 9'h0B7, 9'h000, 9'h000, 9'h000, 9'h000,
        // odd byte then end: still done
        9'h05A, 9'h1FF,
        // end inside address word: truncated
        9'h0DA, 9'h0DA, 9'h000, 9'h100,
        // bad header, ignored byte, silent end
        9'h0FF, 9'h0FF, 9'h000, 9'h1A5
    };

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_data_byte     = '0;
    logic        i_end_of_stream = 1'b0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_result_kind;
    logic [15:0] o_mem_address;
    logic [15:0] o_mem_word;

    int send_idle  = 0;
    int recv_idle  = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int items_sent = 0;
    bit draining   = 1'b0;
    int fail_count;
    int pending;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    object_file_section_loader dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_mem_address   (o_mem_address),
        .o_mem_word      (o_mem_word)
    );

    ofsl_load_checker checker_u (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_result_kind   (o_result_kind),
        .i_mem_address   (o_mem_address),
        .i_mem_word      (o_mem_word),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver: long hold-off on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (!draining)
            items_sent++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_beat(w[15:8], 1'b0);
        send_beat(w[7:0], 1'b0);
    endtask

    task automatic end_stream();
        send_beat(8'($urandom), 1'b1);
    endtask

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return 16'($urandom_range(20, 40));
        return 16'($urandom_range(1, 6));
    endfunction

    function automatic bit is_header(input logic [15:0] w);
        return w == HDR_CODE || w == HDR_DATA || w == HDR_SYMBOL ||
               w == HDR_FNAME || w == HDR_LINE;
    endfunction

    // Code or data section; base often near the top to exercise the wrap
    task automatic send_load_section(input logic [15:0] hdr, input logic [15:0] n_words);
        logic [15:0] base;
        base = ($urandom_range(3) == 0) ? 16'hFFF0 + 16'($urandom_range(15))
                                        : 16'($urandom);
        send_word(hdr);
        send_word(base);
        send_word(n_words);
        repeat (n_words)
            send_word(16'($urandom));
    endtask

    // Symbol, file-name or line section with random content
    task automatic send_skip_section(input logic [15:0] hdr);
        logic [15:0] n;
        n = (hdr == HDR_LINE) ? LINE_LEN : pick_count();
        send_word(hdr);
        if (hdr == HDR_SYMBOL)
            send_word(16'($urandom));
        if (hdr != HDR_LINE)
            send_word(n);
        repeat (n)
            send_beat(8'($urandom), 1'b0);
    endtask

    // One object stream: well-formed sections, then a clean, broken or bad end
    task automatic random_stream();
        int          pick;
        logic [15:0] w;
        repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(9);
            if (pick < 5) begin
                send_load_section((pick < 3) ? HDR_CODE : HDR_DATA, pick_count());
            end else if (pick < 8) begin
                send_skip_section(HEADERS[pick - 3]);
            end else if (pick == 8) begin
                // unknown header, noise ignored until the end beat
                do
                    w = 16'($urandom);
                while (is_header(w));
                send_word(w);
                draining = 1'b1;
                repeat ($urandom_range(5))
                    send_beat(8'($urandom), 1'b0);
                draining = 1'b0;
                end_stream();
                return;
            end else begin
                // cut a section short, sometimes with a huge count
                w = HEADERS[$urandom_range(4)];
                send_word(w);
                if ($urandom_range(1)) begin
                    if (w != HDR_FNAME && w != HDR_LINE)
                        send_word(16'($urandom));
                    send_word($urandom_range(1) ? 16'hFFFF : 16'($urandom));
                end
                repeat ($urandom_range(5))
                    send_beat(8'($urandom), 1'b0);
                end_stream();
                return;
            end
        end
        // dangling odd byte still ends as done
        if ($urandom_range(3) == 0)
            send_beat(8'($urandom), 1'b0);
        end_stream();
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int phase_end;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 3; p++) begin
            send_idle <= SEND_IDLE[p];
            recv_idle <= RECV_IDLE[p];
            @(posedge i_clk);
            if (p == 0) begin
                foreach (DIRECTED[i])
                    send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
            end
            if (p == 1) begin
                // receiver holds off while a long code section streams in
                hold_req <= hold_req + 1;
                send_load_section(HDR_CODE, 16'd48);
                end_stream();
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_stream();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("object_file_section_loader_tb OK");
        else
            $display("object_file_section_loader_tb NOT OK");
        $finish;
    end

    // Run limit
    initial begin
        #4800000;
        $display("object_file_section_loader_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ofsl_pkg.sv
rtl/core/ofsl_in_reg.sv
rtl/core/ofsl_parser.sv
rtl/core/ofsl_out_reg.sv
rtl/core/object_file_section_loader.sv
rtl/core/ofsl_checker.sv
tb/ofsl_load_checker.sv
tb/object_file_section_loader_tb.sv
